FILE: rtl/ttb_pkg.sv
// Shared widths, types and state codes for the triangle tangent basis block.
`timescale 1ns / 1ps
package ttb_pkg;
   localparam int POS_W       = 32;
   localparam int UV_W        = 16;
   localparam int DP_W        = POS_W + 1;
   localparam int DUV_W       = UV_W + 1;
   localparam int PROD_W      = DP_W + DUV_W;
   localparam int NUM_W       = PROD_W + 1;
   localparam int DET_W       = 2 * DUV_W + 1;
   localparam int UV_FRAC_DEF = 12;
   localparam int COMP_N      = 6;

   typedef enum logic [2:0] {
      S_IDLE, S_M1, S_M2, S_SUB, S_LOAD, S_DIV, S_EMIT
   } state_type;

   typedef struct packed {
      logic              done;
      logic              sat;
      logic [POS_W-1:0]  quo;
   } div_res_type;
endpackage

FILE: rtl/ttb_req_if.sv
// Vertex input channel.
`timescale 1ns / 1ps
interface ttb_req_if import ttb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  pos_x;
   logic [POS_W-1:0]  pos_y;
   logic [POS_W-1:0]  pos_z;
   logic [UV_W-1:0]   tex_u;
   logic [UV_W-1:0]   tex_v;
   logic              last_of_mesh;
   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, last_of_mesh,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, last_of_mesh,
                 output ready);
endinterface

FILE: rtl/ttb_rsp_if.sv
// Tangent basis result channel.
`timescale 1ns / 1ps
interface ttb_rsp_if import ttb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        vertex_slot;
   logic [POS_W-1:0]  tangent_x;
   logic [POS_W-1:0]  tangent_y;
   logic [POS_W-1:0]  tangent_z;
   logic [POS_W-1:0]  bitangent_x;
   logic [POS_W-1:0]  bitangent_y;
   logic [POS_W-1:0]  bitangent_z;
   logic              degenerate;
   logic              saturated;
   logic              last;
   modport source (output valid, vertex_slot, tangent_x, tangent_y, tangent_z,
                   bitangent_x, bitangent_y, bitangent_z, degenerate, saturated,
                   last, input ready);
   modport sink (input valid, vertex_slot, tangent_x, tangent_y, tangent_z,
                 bitangent_x, bitangent_y, bitangent_z, degenerate, saturated,
                 last, output ready);
endinterface

FILE: rtl/ttb_div.sv
// Bit-serial signed divider with round-half-away and 32-bit saturation.
`timescale 1ns / 1ps
module ttb_div import ttb_pkg::*; #(
   parameter int UV_FRAC_BITS = UV_FRAC_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DET_W-1:0] det,
   output div_res_type             res
);
   localparam int NW  = NUM_W + UV_FRAC_BITS;
   localparam int CW  = $clog2(NW + 1);
   localparam int RW  = DET_W;

   logic [NW-1:0]  n_ff;
   logic [RW-1:0]  d_ff;
   logic [RW-1:0]  rem_ff;
   logic [CW-1:0]  cnt_ff;
   logic           busy_ff;
   logic           fin_ff;
   logic           neg_ff;
   div_res_type    res_ff;

   logic [NUM_W-1:0] num_mag;
   logic [DET_W-1:0] det_mag;
   logic [RW:0]      rem_sh;
   logic             ge;
   logic [RW:0]      rem_dbl;
   logic [NW:0]      q_rnd;
   logic             sat_pos;
   logic             sat_neg;

   assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign det_mag = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
   assign rem_sh  = {rem_ff, n_ff[NW-1]};
   assign ge      = rem_sh >= {1'b0, d_ff};
   assign rem_dbl = {rem_ff, 1'b0};
   assign q_rnd   = {1'b0, n_ff} + (NW+1)'(rem_dbl >= {1'b0, d_ff});
   assign sat_pos = |q_rnd[NW:POS_W-1];
   assign sat_neg = (|q_rnd[NW:POS_W]) || (q_rnd[POS_W-1] && (|q_rnd[POS_W-2:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         fin_ff      <= 1'b0;
         res_ff.done <= 1'b0;
      end else begin
         res_ff.done <= fin_ff && !start && !busy_ff;
         if (start) begin
            n_ff    <= NW'(num_mag) << UV_FRAC_BITS;
            d_ff    <= det_mag;
            rem_ff  <= '0;
            cnt_ff  <= CW'(NW);
            neg_ff  <= num[NUM_W-1] ^ det[DET_W-1];
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? RW'(rem_sh - {1'b0, d_ff}) : rem_sh[RW-1:0];
            n_ff   <= {n_ff[NW-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff <= 1'b0;
            if (neg_ff) begin
               res_ff.sat <= sat_neg;
               res_ff.quo <= sat_neg ? {1'b1, {(POS_W-1){1'b0}}} :
                                       POS_W'(0 - q_rnd[POS_W-1:0]);
            end else begin
               res_ff.sat <= sat_pos;
               res_ff.quo <= sat_pos ? {1'b0, {(POS_W-1){1'b1}}} : q_rnd[POS_W-1:0];
            end
         end
      end
   end

   assign res = res_ff;
endmodule

FILE: rtl/triangle_tangent_basis_top.sv
// Top level: per-triangle tangent and bitangent from positions and UVs.
//
// req_chan takes one vertex per item (valid/ready). The first two vertices
// of a triangle are held; last_of_mesh on either drops the partial triangle.
// The third vertex starts the computation: one shared 33x17 multiplier
// forms the UV determinant and the six numerators, and one bit-serial
// divider (one quotient bit per cycle) turns each numerator into a
// rounded, saturated Q16.16 component.
// For a third vertex: accept, then the determinant (S_M1, S_M2, S_SUB),
// then each of the six components (S_M1, S_M2, S_SUB, S_LOAD, S_DIV), then three
// items on rsp_chan, slots 0..2, last on slot 2. A degenerate triangle
// skips the components. req_chan.ready is high only while idle, so first
// and second vertices are accepted without leaving S_IDLE.
// rsp_chan holds each item until taken; a stall simply holds the block.
// Reset clears the vertex phase and the sequencer; held vertex data is
// left as is.
`timescale 1ns / 1ps
module triangle_tangent_basis_top import ttb_pkg::*; #(
   parameter int UV_FRAC_BITS = UV_FRAC_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ttb_req_if.sink   req_chan,
   ttb_rsp_if.source rsp_chan
);
   state_type state_ff, state_in;

   logic [1:0]             phase_ff;
   logic [POS_W-1:0]       p0_ff [3];
   logic [POS_W-1:0]       p1_ff [3];
   logic [UV_W-1:0]        uv0_ff [2];
   logic [UV_W-1:0]        uv1_ff [2];
   logic signed [DP_W-1:0]  dp1_ff [3];
   logic signed [DP_W-1:0]  dp2_ff [3];
   logic signed [DUV_W-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [PROD_W-1:0] prod_ff, first_ff;
   logic signed [NUM_W-1:0]  num_ff;
   logic signed [DET_W-1:0]  det_ff;
   logic [2:0]             comp_ff;
   logic [POS_W-1:0]       res_ff [COMP_N];
   logic                   degen_ff;
   logic                   sat_ff;
   logic [1:0]             slot_ff;

   logic                   accept;
   logic                   third;
   logic [POS_W-1:0]       in_pos [3];
   logic signed [DP_W-1:0]  op_a;
   logic signed [DUV_W-1:0] op_b;
   logic signed [NUM_W-1:0] diff;
   logic [1:0]             idx;
   logic                   div_start;
   div_res_type            div_res;

   assign in_pos[0] = req_chan.pos_x;
   assign in_pos[1] = req_chan.pos_y;
   assign in_pos[2] = req_chan.pos_z;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign third          = (phase_ff == 2'd2);
   assign div_start      = (state_ff == S_LOAD);
   assign diff           = NUM_W'(first_ff) - NUM_W'(prod_ff);
   assign idx            = (comp_ff >= 3'd4) ? 2'(comp_ff - 3'd4) : 2'(comp_ff - 3'd1);

   always_comb begin
      op_a = '0;
      op_b = '0;
      if (comp_ff == 3'd0) begin
         op_a = (state_ff == S_M1) ? DP_W'(du1_ff) : DP_W'(dv1_ff);
         op_b = (state_ff == S_M1) ? dv2_ff : du2_ff;
      end else if (comp_ff <= 3'd3) begin
         op_a = (state_ff == S_M1) ? dp1_ff[idx] : dp2_ff[idx];
         op_b = (state_ff == S_M1) ? dv2_ff : dv1_ff;
      end else begin
         op_a = (state_ff == S_M1) ? dp2_ff[idx] : dp1_ff[idx];
         op_b = (state_ff == S_M1) ? du1_ff : du2_ff;
      end
   end

   ttb_div #(.UV_FRAC_BITS(UV_FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .det   (det_ff),
      .res   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && third) state_in = S_M1;
         end
         S_M1: state_in = S_M2;
         S_M2: state_in = S_SUB;
         S_SUB: begin
            if (comp_ff != 3'd0) state_in = S_LOAD;
            else if (diff == '0) state_in = S_EMIT;
            else state_in = S_M1;
         end
         S_LOAD: state_in = S_DIV;
         S_DIV: begin
            if (div_res.done) state_in = (comp_ff == 3'(COMP_N)) ? S_EMIT : S_M1;
         end
         S_EMIT: begin
            if (rsp_chan.ready && slot_ff == 2'd2) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         slot_ff  <= 2'd0;
      end else begin
         if (accept) begin
            if (third) begin
               phase_ff <= 2'd0;
            end else begin
               phase_ff <= req_chan.last_of_mesh ? 2'd0 : ((phase_ff == 2'd1) ? 2'd2 : 2'd1);
            end
         end
         if (state_ff == S_EMIT && rsp_chan.ready) begin
            slot_ff <= (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (!third) begin
            for (int i = 0; i < 3; i++) begin
               if (phase_ff == 2'd1) p1_ff[i] <= in_pos[i];
               else p0_ff[i] <= in_pos[i];
            end
            if (phase_ff == 2'd1) begin
               uv1_ff[0] <= req_chan.tex_u;
               uv1_ff[1] <= req_chan.tex_v;
            end else begin
               uv0_ff[0] <= req_chan.tex_u;
               uv0_ff[1] <= req_chan.tex_v;
            end
         end else begin
            for (int i = 0; i < 3; i++) begin
               dp1_ff[i] <= DP_W'(signed'(p1_ff[i])) - DP_W'(signed'(p0_ff[i]));
               dp2_ff[i] <= DP_W'(signed'(in_pos[i])) - DP_W'(signed'(p0_ff[i]));
            end
            du1_ff   <= DUV_W'(signed'(uv1_ff[0])) - DUV_W'(signed'(uv0_ff[0]));
            dv1_ff   <= DUV_W'(signed'(uv1_ff[1])) - DUV_W'(signed'(uv0_ff[1]));
            du2_ff   <= DUV_W'(signed'(req_chan.tex_u)) - DUV_W'(signed'(uv0_ff[0]));
            dv2_ff   <= DUV_W'(signed'(req_chan.tex_v)) - DUV_W'(signed'(uv0_ff[1]));
            comp_ff  <= 3'd0;
            sat_ff   <= 1'b0;
            degen_ff <= 1'b0;
         end
      end
      if (state_ff == S_M1) begin
         prod_ff <= op_a * op_b;
      end
      if (state_ff == S_M2) begin
         first_ff <= prod_ff;
         prod_ff  <= op_a * op_b;
      end
      if (state_ff == S_SUB) begin
         if (comp_ff == 3'd0) begin
            det_ff  <= DET_W'(diff);
            comp_ff <= 3'd1;
            if (diff == '0) begin
               degen_ff <= 1'b1;
               for (int i = 0; i < COMP_N; i++) res_ff[i] <= '0;
            end
         end else begin
            num_ff <= diff;
         end
      end
      if (state_ff == S_DIV && div_res.done) begin
         res_ff[3'(comp_ff - 3'd1)] <= div_res.quo;
         sat_ff  <= sat_ff | div_res.sat;
         comp_ff <= comp_ff + 3'd1;
      end
   end

   assign rsp_chan.valid       = (state_ff == S_EMIT);
   assign rsp_chan.vertex_slot = slot_ff;
   assign rsp_chan.tangent_x   = res_ff[0];
   assign rsp_chan.tangent_y   = res_ff[1];
   assign rsp_chan.tangent_z   = res_ff[2];
   assign rsp_chan.bitangent_x = res_ff[3];
   assign rsp_chan.bitangent_y = res_ff[4];
   assign rsp_chan.bitangent_z = res_ff[5];
   assign rsp_chan.degenerate  = degen_ff;
   assign rsp_chan.saturated   = sat_ff;
   assign rsp_chan.last        = (slot_ff == 2'd2);

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_chan.ready)
      else $error("input ready while busy");

   a_degen_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && degen_ff) |-> (!sat_ff && res_ff[0] == '0 && res_ff[5] == '0))
      else $error("degenerate item carries data");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (slot_ff != 2'd3))
      else $error("bad vertex slot");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && slot_ff == 2'd2) |=> req_chan.ready)
      else $error("not idle after last item");
endmodule
